[sv/gps_pkg.sv]
// Package for the gain-scheduled PID steering unit.
// Holds widths, constants, sequencer codes and shared types; depends on nothing.
package gps_pkg;

    localparam int ANGLE_W   = 16;
    localparam int SPEED_W   = 16;
    localparam int DT_W      = 20;
    localparam int GAIN_W    = 20;
    localparam int DRIVE_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 20;
    localparam int INTEG_W   = 24;

    localparam int INTEGRAL_LIMIT = 4096;
    localparam int PI_Q12         = 12868;
    localparam int TWO_PI_Q12     = 25736;
    localparam int WRAP_BIAS      = PI_Q12 + 3 * TWO_PI_Q12;
    localparam int TIME_BASE_US   = 40000;

    localparam int ALU_A_W    = 38;
    localparam int ALU_MCAND_W = 32;
    localparam int ALU_B_W    = 21;
    localparam int ALU_R_W    = 53;
    localparam int ALU_CNT_W  = 6;
    localparam int MUL_STEPS  = ALU_B_W;
    localparam int DIV_STEPS  = ALU_A_W;
    localparam int ACC_W      = 54;

    localparam logic [CFG_IDX_W-1:0] REG_LOW_BP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_BP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KP_LOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KP_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KI_LOW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_KI_HIGH = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_KD_LOW  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_KD_HIGH = 3'd7;

    typedef enum logic [0:0] {
        ALU_MUL,
        ALU_DIV
    } gps_alu_op_t;

    typedef struct packed {
        logic        start;
        gps_alu_op_t op;
    } gps_alu_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } gps_alu_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRAP,
        ST_ISSUE,
        ST_WAIT,
        ST_DONE
    } gps_state_t;

    typedef enum logic [2:0] {
        PH_MUL_I,
        PH_DIV_I,
        PH_MUL_D,
        PH_DIV_D,
        PH_GMUL,
        PH_GDIV,
        PH_TMUL
    } gps_phase_t;

    function automatic logic [31:0] abs32(input logic signed [31:0] x);
        logic [31:0] r;
        r = x[31] ? 32'(-x) : 32'(x);
        return r;
    endfunction

endpackage

[sv/gps_if.sv]
// Stream interfaces for input samples and steering commands.
// Depends on gps_pkg for field widths.
interface gps_in_if import gps_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [ANGLE_W-1:0] wanted_angle;
    logic signed [ANGLE_W-1:0] measured_angle;
    logic signed [SPEED_W-1:0] vehicle_speed;
    logic        [DT_W-1:0]    elapsed_us;

    modport source (output valid, wanted_angle, measured_angle, vehicle_speed, elapsed_us,
                    input ready);
    modport sink (input valid, wanted_angle, measured_angle, vehicle_speed, elapsed_us,
                  output ready);
endinterface

interface gps_out_if import gps_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [DRIVE_W-1:0] steer_drive;

    modport source (output valid, steer_drive, input ready);
    modport sink (input valid, steer_drive, output ready);
endinterface

[sv/gain_scheduled_pid_steer_unit.sv]
// Gain-scheduled PID steering unit: one steering command per input sample.
// Depends on gps_pkg, gps_if and gps_serial_alu.
//
// Each sample is processed in full before its command is registered, and the unit returns
// to idle, ready for the next sample, as the command is registered. The angle wrap runs
// first. A single bit-serial unit then performs every multiply and divide in turn: for
// the integral, for the derivative, and for each of the three gains. A gain skips the
// interpolation when the speed lies outside the breakpoint band or the breakpoints are
// not ordered, and is interpolated otherwise. Samples are processed one at a time. A
// finished command waits in an output register while the next sample is already
// accepted.
module gain_scheduled_pid_steer_unit import gps_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DAT_W-1:0]  cfg_data,
    gps_in_if.sink                sample,
    gps_out_if.source             drive
);

    gps_state_t state_reg, state_next;
    gps_phase_t phase_reg, phase_next;
    logic [1:0] k_reg, k_next;

    logic signed [SPEED_W-1:0] low_bp_reg, high_bp_reg;
    logic signed [GAIN_W-1:0]  kp_lo_reg, kp_hi_reg, ki_lo_reg, ki_hi_reg, kd_lo_reg, kd_hi_reg;

    logic        [17:0]         t_reg, t_next;
    logic signed [SPEED_W-1:0]  speed_reg, speed_next;
    logic        [DT_W-1:0]     dt_reg, dt_next;
    logic signed [14:0]         e_reg, e_next;
    logic                       neg_reg, neg_next;
    logic        [ALU_A_W-1:0]  mag_reg, mag_next;
    logic signed [INTEG_W-1:0]  integ_reg, integ_next;
    logic signed [ANGLE_W-1:0]  prev_reg, prev_next;
    logic signed [31:0]         deriv_reg, deriv_next;
    logic signed [ALU_B_W-1:0]  gain_reg, gain_next;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic                       out_valid_reg, out_valid_next;
    logic signed [DRIVE_W-1:0]  out_data_reg, out_data_next;

    gps_alu_cmd_t          alu_cmd;
    gps_alu_stat_t         alu_stat;
    logic [ALU_A_W-1:0]    alu_a;
    logic [ALU_B_W-1:0]    alu_b;
    logic [ALU_R_W-1:0]    alu_result;

    logic signed [GAIN_W-1:0]  g_lo, g_hi;
    logic signed [ALU_B_W-1:0] g_diff;
    logic signed [16:0]        speed_off, bp_span, diff_e;
    logic signed [31:0]        term;
    logic signed [20:0]        q_small;
    logic signed [INTEG_W:0]   integ_sum;
    logic signed [ACC_W-1:0]   prod;
    logic signed [25:0]        sat;
    logic signed [26:0]        rounded;
    logic                      accept_in;

    gps_serial_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (alu_cmd),
        .a      (alu_a),
        .b      (alu_b),
        .stat   (alu_stat),
        .result (alu_result)
    );

    assign sample.ready = (state_reg == ST_IDLE);
    assign accept_in    = sample.valid && sample.ready;
    assign drive.valid  = out_valid_reg;
    assign drive.steer_drive = out_data_reg;

    always_comb
    begin
        case (k_reg)
            2'd0:
            begin
                g_lo = kp_lo_reg;
                g_hi = kp_hi_reg;
                term = 32'(e_reg);
            end
            2'd1:
            begin
                g_lo = ki_lo_reg;
                g_hi = ki_hi_reg;
                term = 32'(integ_reg);
            end
            default:
            begin
                g_lo = kd_lo_reg;
                g_hi = kd_hi_reg;
                term = deriv_reg;
            end
        endcase
    end

    assign g_diff    = ALU_B_W'(g_hi) - ALU_B_W'(g_lo);
    assign speed_off = 17'(speed_reg) - 17'(low_bp_reg);
    assign bp_span   = 17'(high_bp_reg) - 17'(low_bp_reg);
    assign diff_e    = 17'(e_reg) - 17'(prev_reg);
    assign q_small   = neg_reg ? -21'(alu_result[19:0]) : 21'(alu_result[19:0]);
    assign integ_sum = 25'(integ_reg) + 25'(q_small);
    assign prod      = neg_reg ? -ACC_W'(alu_result) : ACC_W'(alu_result);
    assign sat       = (acc_reg > ACC_W'(1 << 24)) ? 26'sd16777216 :
                       (acc_reg < -ACC_W'(1 << 24)) ? -26'sd16777216 : 26'(acc_reg);
    assign rounded   = (27'(sat) + 27'sd512) >>> 10;

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        k_next         = k_reg;
        t_next         = t_reg;
        speed_next     = speed_reg;
        dt_next        = dt_reg;
        e_next         = e_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        integ_next     = integ_reg;
        prev_next      = prev_reg;
        deriv_next     = deriv_reg;
        gain_next      = gain_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        alu_cmd.start  = 1'b0;
        alu_cmd.op     = ALU_MUL;
        alu_a          = '0;
        alu_b          = '0;

        if (drive.valid && drive.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept_in)
                begin
                    t_next = 18'(17'(sample.wanted_angle) - 17'(sample.measured_angle))
                             + 18'(WRAP_BIAS);
                    speed_next = sample.vehicle_speed;
                    dt_next    = (sample.elapsed_us == '0) ? DT_W'(1) : sample.elapsed_us;
                    acc_next   = '0;
                    state_next = ST_WRAP;
                end
            end
            ST_WRAP:
            begin
                if (t_reg >= 18'(TWO_PI_Q12))
                begin
                    t_next = t_reg - 18'(TWO_PI_Q12);
                end
                else
                begin
                    e_next     = 15'(19'(t_reg) - 19'(PI_Q12));
                    phase_next = PH_MUL_I;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                state_next = ST_WAIT;
                alu_cmd.start = 1'b1;
                case (phase_reg)
                    PH_MUL_I:
                    begin
                        alu_a    = ALU_A_W'(dt_reg);
                        alu_b    = ALU_B_W'(abs32(32'(e_reg)));
                        neg_next = e_reg[14];
                    end
                    PH_DIV_I:
                    begin
                        alu_cmd.op = ALU_DIV;
                        alu_a      = mag_reg;
                        alu_b      = ALU_B_W'(TIME_BASE_US);
                    end
                    PH_MUL_D:
                    begin
                        alu_a    = ALU_A_W'(abs32(32'(diff_e)));
                        alu_b    = ALU_B_W'(TIME_BASE_US);
                        neg_next = diff_e[16];
                    end
                    PH_DIV_D:
                    begin
                        alu_cmd.op = ALU_DIV;
                        alu_a      = mag_reg;
                        alu_b      = ALU_B_W'(dt_reg);
                    end
                    PH_GMUL:
                    begin
                        if (high_bp_reg <= low_bp_reg || speed_reg <= low_bp_reg)
                        begin
                            alu_cmd.start = 1'b0;
                            gain_next  = ALU_B_W'(g_lo);
                            phase_next = PH_TMUL;
                            state_next = ST_ISSUE;
                        end
                        else if (speed_reg >= high_bp_reg)
                        begin
                            alu_cmd.start = 1'b0;
                            gain_next  = ALU_B_W'(g_hi);
                            phase_next = PH_TMUL;
                            state_next = ST_ISSUE;
                        end
                        else
                        begin
                            alu_a    = ALU_A_W'(speed_off[15:0]);
                            alu_b    = ALU_B_W'(abs32(32'(g_diff)));
                            neg_next = g_diff[ALU_B_W-1];
                        end
                    end
                    PH_GDIV:
                    begin
                        alu_cmd.op = ALU_DIV;
                        alu_a      = mag_reg;
                        alu_b      = ALU_B_W'(bp_span[15:0]);
                    end
                    default:
                    begin
                        alu_a    = ALU_A_W'(abs32(term));
                        alu_b    = ALU_B_W'(abs32(32'(gain_reg)));
                        neg_next = term[31] ^ gain_reg[ALU_B_W-1];
                    end
                endcase
            end
            ST_WAIT:
            begin
                if (alu_stat.done)
                begin
                    state_next = ST_ISSUE;
                    case (phase_reg)
                        PH_MUL_I:
                        begin
                            mag_next   = alu_result[ALU_A_W-1:0];
                            phase_next = PH_DIV_I;
                        end
                        PH_DIV_I:
                        begin
                            if (integ_sum > 25'(INTEGRAL_LIMIT))
                            begin
                                integ_next = INTEG_W'(INTEGRAL_LIMIT);
                            end
                            else if (integ_sum < -25'(INTEGRAL_LIMIT))
                            begin
                                integ_next = -INTEG_W'(INTEGRAL_LIMIT);
                            end
                            else
                            begin
                                integ_next = INTEG_W'(integ_sum);
                            end
                            phase_next = PH_MUL_D;
                        end
                        PH_MUL_D:
                        begin
                            mag_next   = alu_result[ALU_A_W-1:0];
                            phase_next = PH_DIV_D;
                        end
                        PH_DIV_D:
                        begin
                            deriv_next = neg_reg ? -32'(alu_result[30:0])
                                                 : 32'(alu_result[30:0]);
                            prev_next  = ANGLE_W'(e_reg);
                            k_next     = 2'd0;
                            phase_next = PH_GMUL;
                        end
                        PH_GMUL:
                        begin
                            mag_next   = alu_result[ALU_A_W-1:0];
                            phase_next = PH_GDIV;
                        end
                        PH_GDIV:
                        begin
                            gain_next  = ALU_B_W'(g_lo) + q_small;
                            phase_next = PH_TMUL;
                        end
                        default:
                        begin
                            acc_next = acc_reg + prod;
                            if (k_reg == 2'd2)
                            begin
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                k_next     = k_reg + 2'd1;
                                phase_next = PH_GMUL;
                            end
                        end
                    endcase
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || drive.ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = rounded[DRIVE_W-1:0];
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_MUL_I;
            k_reg         <= 2'd0;
            integ_reg     <= '0;
            prev_reg      <= '0;
            out_valid_reg <= 1'b0;
            low_bp_reg    <= 16'sd0;
            high_bp_reg   <= 16'sd512;
            kp_lo_reg     <= 20'sd4096;
            kp_hi_reg     <= 20'sd4096;
            ki_lo_reg     <= '0;
            ki_hi_reg     <= '0;
            kd_lo_reg     <= '0;
            kd_hi_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            k_reg         <= k_next;
            integ_reg     <= integ_next;
            prev_reg      <= prev_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write_en)
            begin
                case (cfg_index)
                    REG_LOW_BP:  low_bp_reg  <= cfg_data[SPEED_W-1:0];
                    REG_HIGH_BP: high_bp_reg <= cfg_data[SPEED_W-1:0];
                    REG_KP_LOW:  kp_lo_reg   <= cfg_data;
                    REG_KP_HIGH: kp_hi_reg   <= cfg_data;
                    REG_KI_LOW:  ki_lo_reg   <= cfg_data;
                    REG_KI_HIGH: ki_hi_reg   <= cfg_data;
                    REG_KD_LOW:  kd_lo_reg   <= cfg_data;
                    REG_KD_HIGH: kd_hi_reg   <= cfg_data;
                    default:     kd_hi_reg   <= kd_hi_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg        <= t_next;
        speed_reg    <= speed_next;
        dt_reg       <= dt_next;
        e_reg        <= e_next;
        neg_reg      <= neg_next;
        mag_reg      <= mag_next;
        deriv_reg    <= deriv_next;
        gain_reg     <= gain_next;
        acc_reg      <= acc_next;
        out_data_reg <= out_data_next;
    end

    a_integ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (integ_reg <= INTEG_W'(INTEGRAL_LIMIT)) && (integ_reg >= -INTEG_W'(INTEGRAL_LIMIT)))
        else $error("integral state left its clamp band");

    a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg <= 16'sd16384) && (out_data_reg >= -16'sd16384))
        else $error("steering command outside [-1, 1]");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        alu_stat.done |-> (state_reg == ST_WAIT))
        else $error("arithmetic unit finished outside a wait state");

    a_accept_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        accept_in |=> (state_reg == ST_WRAP))
        else $error("accepted transaction did not start the angle wrap");

    a_no_issue_busy: assert property (@(posedge clk) disable iff (!rst_n)
        alu_cmd.start |-> !alu_stat.busy)
        else $error("arithmetic unit started while busy");

endmodule

[sv/gps_serial_alu.sv]
// Bit-serial unsigned multiplier and restoring divider, one bit per cycle.
// Depends on gps_pkg for widths and command types.
module gps_serial_alu import gps_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  gps_alu_cmd_t         cmd,
    input  logic [ALU_A_W-1:0]   a,
    input  logic [ALU_B_W-1:0]   b,
    output gps_alu_stat_t        stat,
    output logic [ALU_R_W-1:0]   result
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [ALU_CNT_W-1:0] cnt_reg;
    gps_alu_op_t          op_reg;
    logic [ALU_R_W-1:0]   acc_reg;
    logic [ALU_R_W-1:0]   mcand_reg;
    logic [ALU_B_W-1:0]   mplier_reg;
    logic [ALU_B_W-1:0]   divisor_reg;
    logic [ALU_B_W-1:0]   rem_reg;
    logic [ALU_A_W-1:0]   dq_reg;
    logic [ALU_B_W:0]     rem_sh;
    logic                 last_step;

    assign rem_sh = {rem_reg, dq_reg[ALU_A_W-1]};
    assign last_step = (op_reg == ALU_MUL) ? (cnt_reg == ALU_CNT_W'(MUL_STEPS - 1))
                                           : (cnt_reg == ALU_CNT_W'(DIV_STEPS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= ALU_MUL;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                op_reg   <= cmd.op;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            acc_reg     <= '0;
            mcand_reg   <= ALU_R_W'(a[ALU_MCAND_W-1:0]);
            mplier_reg  <= b;
            divisor_reg <= b;
            rem_reg     <= '0;
            dq_reg      <= a;
        end
        else if (busy_reg)
        begin
            if (op_reg == ALU_MUL)
            begin
                if (mplier_reg[0])
                begin
                    acc_reg <= acc_reg + mcand_reg;
                end
                mcand_reg  <= {mcand_reg[ALU_R_W-2:0], 1'b0};
                mplier_reg <= {1'b0, mplier_reg[ALU_B_W-1:1]};
            end
            else
            begin
                if (rem_sh >= {1'b0, divisor_reg})
                begin
                    rem_reg <= ALU_B_W'(rem_sh - {1'b0, divisor_reg});
                    dq_reg  <= {dq_reg[ALU_A_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh[ALU_B_W-1:0];
                    dq_reg  <= {dq_reg[ALU_A_W-2:0], 1'b0};
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result = (op_reg == ALU_MUL) ? acc_reg : ALU_R_W'(dq_reg);

endmodule

[bench/steer_checker.sv]
// Checker for the gain-scheduled PID steering unit: watches the configuration port and both
// streams, predicts each steering command and compares it with the one the unit delivers.
// Depends on gps_pkg and the stream interfaces in gps_if.
module steer_checker import gps_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    gps_in_if                    sample,
    gps_out_if                   drive,
    output int                   fail_count,
    output int                   pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    longint gain_reg [8];
    longint error_integral;
    longint previous_error;
    logic signed [DRIVE_W-1:0] expected_drive [$];

    function automatic longint scheduled_gain(longint speed, longint g_lo, longint g_hi);
        longint lo;
        longint hi;
        lo = gain_reg[REG_LOW_BP];
        hi = gain_reg[REG_HIGH_BP];
        if (hi <= lo || speed <= lo)
            return g_lo;
        if (speed >= hi)
            return g_hi;
        return g_lo + ((g_hi - g_lo) * (speed - lo)) / (hi - lo);
    endfunction

    function automatic logic signed [DRIVE_W-1:0] predict_drive(
        logic signed [ANGLE_W-1:0] wanted, logic signed [ANGLE_W-1:0] measured,
        logic signed [SPEED_W-1:0] speed, logic [DT_W-1:0] elapsed);
        longint err;
        longint dt;
        longint integ;
        longint deriv;
        longint kp;
        longint ki;
        longint kd;
        longint sum;
        longint biased;
        dt = (elapsed == '0) ? 64'sd1 : longint'(elapsed);
        err = longint'(wanted) - longint'(measured);
        err = ((err + WRAP_BIAS) % TWO_PI_Q12) - PI_Q12;
        integ = error_integral + (err * dt) / TIME_BASE_US;
        if (integ > INTEGRAL_LIMIT)
            integ = INTEGRAL_LIMIT;
        if (integ < -INTEGRAL_LIMIT)
            integ = -INTEGRAL_LIMIT;
        error_integral = integ;
        deriv = ((err - previous_error) * TIME_BASE_US) / dt;
        previous_error = err;
        kp = scheduled_gain(speed, gain_reg[REG_KP_LOW], gain_reg[REG_KP_HIGH]);
        ki = scheduled_gain(speed, gain_reg[REG_KI_LOW], gain_reg[REG_KI_HIGH]);
        kd = scheduled_gain(speed, gain_reg[REG_KD_LOW], gain_reg[REG_KD_HIGH]);
        sum = err * kp + integ * ki + deriv * kd;
        if (sum > 64'sd16777216)
            sum = 64'sd16777216;
        if (sum < -64'sd16777216)
            sum = -64'sd16777216;
        biased = sum + 64'sd16777216 + 64'sd512;
        return DRIVE_W'((biased >>> 10) - 64'sd16384);
    endfunction

    assign pending_count = expected_drive.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg = '{0, 512, 4096, 4096, 0, 0, 0, 0};
            error_integral = 0;
            previous_error = 0;
            expected_drive.delete();
            fail_count = 0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                if (cfg_index == REG_LOW_BP || cfg_index == REG_HIGH_BP)
                    gain_reg[cfg_index] = longint'($signed(cfg_data[15:0]));
                else
                    gain_reg[cfg_index] = longint'($signed(cfg_data));
            end
            if (drive.valid && drive.ready)
            begin
                if (expected_drive.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("tb: unexpected command %0d", drive.steer_drive);
                end
                else
                begin
                    logic signed [DRIVE_W-1:0] want;
                    want = expected_drive.pop_front();
                    if (want !== drive.steer_drive)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("tb: steer_drive mismatch, expected %0d actual %0d",
                                     want, drive.steer_drive);
                    end
                end
            end
            if (sample.valid && sample.ready)
                expected_drive.push_back(predict_drive(sample.wanted_angle,
                    sample.measured_angle, sample.vehicle_speed, sample.elapsed_us));
        end
    end
endmodule

[bench/testbench.sv]
// Top of the steering unit bench: clock, reset, configuration phases and sample stimulus
// with random idling on both streams. Depends on gps_pkg, gps_if, the unit and steer_checker.
module testbench import gps_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;
    logic                 steady = 1'b0;
    int                   fail_count;
    int                   pending_count;

    gps_in_if  sample_ch ();
    gps_out_if drive_ch ();

    gain_scheduled_pid_steer_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample       (sample_ch),
        .drive        (drive_ch)
    );

    steer_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write_en  (cfg_write_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .sample        (sample_ch),
        .drive         (drive_ch),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always #1 clk = ~clk;

    initial
    begin
        sample_ch.valid = 1'b0;
        sample_ch.wanted_angle = '0;
        sample_ch.measured_angle = '0;
        sample_ch.vehicle_speed = '0;
        sample_ch.elapsed_us = '0;
        drive_ch.ready = 1'b0;
    end

    function automatic int idle_cycles();
        if (steady || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 14);
    endfunction

    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = idle_cycles();
            if (stall > 0)
            begin
                drive_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            drive_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!drive_ch.valid);
        end
    end

    task automatic send_sample(int wanted, int measured, int speed, int elapsed);
        int gap;
        gap = idle_cycles();
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.wanted_angle <= ANGLE_W'(wanted);
        sample_ch.measured_angle <= ANGLE_W'(measured);
        sample_ch.vehicle_speed <= SPEED_W'(speed);
        sample_ch.elapsed_us <= DT_W'(elapsed);
        do
            @(posedge clk);
        while (!sample_ch.ready);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DAT_W'(value);
        @(posedge clk);
    endtask

    task automatic drain();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic load_gains(int lo_bp, int hi_bp, int kpl, int kph, int kil, int kih,
                              int kdl, int kdh);
        write_reg(REG_LOW_BP, lo_bp);
        write_reg(REG_HIGH_BP, hi_bp);
        write_reg(REG_KP_LOW, kpl);
        write_reg(REG_KP_HIGH, kph);
        write_reg(REG_KI_LOW, kil);
        write_reg(REG_KI_HIGH, kih);
        write_reg(REG_KD_LOW, kdl);
        write_reg(REG_KD_HIGH, kdh);
        cfg_write_en <= 1'b0;
        @(posedge clk);
    endtask

    function automatic int rand_gain();
        if ($urandom_range(0, 1) == 0)
            return $urandom_range(0, 16383) - 8192;
        return $urandom_range(0, 1048575) - 524288;
    endfunction

    function automatic int rand_angle();
        return $urandom_range(0, 65535) - 32768;
    endfunction

    initial
    begin
        int lo_bp;
        int hi_bp;
        int wanted;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_sample(0, 0, 0, 40000);
        send_sample(32767, -32768, 256, 1);
        send_sample(-32768, 32767, 256, 0);
        send_sample(12868, 0, -32768, 1048575);
        send_sample(-12868, 0, 32767, 40000);
        send_sample(4096, -4096, 512, 100);
        drain();

        load_gains(-32768, 32767, 524287, -524288, -524288, 524287, 524287, -524288);
        send_sample(32767, 0, -32768, 1048575);
        send_sample(-32768, 0, 32767, 1048575);
        send_sample(1000, 0, 0, 1);
        send_sample(-1000, 500, 100, 0);
        send_sample(100, 0, 32767, 20000);
        drain();

        load_gains(32767, -32768, 2000, 9000, 300, -300, 50, -50);
        send_sample(2000, 0, 32767, 40000);
        send_sample(-2000, 0, -32768, 40000);
        send_sample(0, 2000, 0, 10);
        send_sample(0, 0, 1000, 1048575);
        drain();

        load_gains(100, 100, -4096, 4096, 512, 1024, 8, 16);
        send_sample(500, 0, 100, 5000);
        send_sample(500, 0, 99, 5000);
        send_sample(500, 0, 101, 5000);
        drain();

        for (int phase = 0; phase < 8; phase++)
        begin
            lo_bp = $urandom_range(0, 65535) - 32768;
            hi_bp = $urandom_range(0, 65535) - 32768;
            if ($urandom_range(0, 3) != 0)
            begin
                lo_bp = $urandom_range(0, 2048) - 512;
                hi_bp = lo_bp + $urandom_range(0, 4096);
            end
            load_gains(lo_bp, hi_bp, rand_gain(), rand_gain(), rand_gain(), rand_gain(),
                       rand_gain(), rand_gain());
            steady = (phase % 3 == 2);
            for (int n = 0; n < 75; n++)
            begin
                if ($urandom_range(0, 2) == 0)
                    send_sample(rand_angle(), rand_angle(), rand_angle(),
                                $urandom_range(0, 1048575));
                else
                begin
                    wanted = $urandom_range(0, 8192) - 4096;
                    send_sample(wanted, wanted + $urandom_range(0, 800) - 400,
                                $urandom_range(0, 4096) - 1024 + lo_bp,
                                $urandom_range(1, 100000));
                end
            end
            drain();
        end
        steady = 1'b0;

        repeat (400) @(posedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("tb: failure");
        $finish;
    end
endmodule
